// ===== rtl/idc_pkg.sv =====
// ============================================================================
// idc_pkg: shared types and constants for the image dimension capper
// Sizes of the dimension path, tier limits, divider command/status
// structs and the nine-tenths shrink helper.
// ============================================================================
package idc_pkg;

    // Dimension field width and the positive magnitude part of it
    localparam int DIM_BITS = 16;
    localparam int MAG_BITS = DIM_BITS - 1;

    // All tier limits fit in LIM_BITS; pixel limits in PIX_BITS
    localparam int LIM_BITS = 10;
    localparam int PIX_BITS = 17;
    localparam int PRD_BITS = 2 * LIM_BITS;

    // Divider sizes: dividend is a magnitude times a limit
    localparam int DVD_BITS = MAG_BITS + LIM_BITS;
    localparam int CNT_BITS = $clog2(DVD_BITS);

    // Free-memory tier thresholds
    localparam logic [31:0] FREE_HI  = 32'd1048576;
    localparam logic [31:0] FREE_MID = 32'd524288;

    // Tier limits
    localparam logic [LIM_BITS-1:0] MAXW_HI  = LIM_BITS'(640);
    localparam logic [LIM_BITS-1:0] MAXH_HI  = LIM_BITS'(512);
    localparam logic [PIX_BITS-1:0] MAXP_HI  = PIX_BITS'(102400);
    localparam logic [LIM_BITS-1:0] MAXW_MID = LIM_BITS'(480);
    localparam logic [LIM_BITS-1:0] MAXH_MID = LIM_BITS'(360);
    localparam logic [PIX_BITS-1:0] MAXP_MID = PIX_BITS'(48000);
    localparam logic [LIM_BITS-1:0] MAXW_LO  = LIM_BITS'(320);
    localparam logic [LIM_BITS-1:0] MAXH_LO  = LIM_BITS'(256);
    localparam logic [PIX_BITS-1:0] MAXP_LO  = PIX_BITS'(24576);

    // Reciprocal of ten: (n * RECIP10) >> RECIP_SHIFT is exact for n < 2**16
    localparam int          RECIP_SHIFT = 19;
    localparam logic [15:0] RECIP10     = 16'd52429;

    // Divider command from the sequencer
    typedef struct packed {
        logic                start;
        logic [DVD_BITS-1:0] dividend;
        logic [MAG_BITS-1:0] divisor;
    } div_cmd_t;

    // Divider status back to the sequencer
    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DVD_BITS-1:0] quotient;
    } div_rsp_t;

    // Shrink one side to nine tenths, floored at 1
    function automatic logic [LIM_BITS-1:0] shrink_side(input logic [LIM_BITS-1:0] x);
        logic [LIM_BITS+3:0]  x9;
        logic [LIM_BITS+19:0] prod;
        logic [LIM_BITS-1:0]  q;
        x9   = {x, 3'b000} + (LIM_BITS+4)'(x);
        prod = (LIM_BITS+20)'(x9) * (LIM_BITS+20)'(RECIP10);
        q    = prod[RECIP_SHIFT +: LIM_BITS];
        if (q == '0)
        begin
            q = LIM_BITS'(1);
        end
        return q;
    endfunction

endpackage

// ===== rtl/idc_div.sv =====
// ============================================================================
// idc_div: shared restoring divider
// Unsigned divide, one quotient bit per cycle. A start loads the operands;
// done pulses for one cycle once the quotient is ready.
// ============================================================================
module idc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  idc_pkg::div_cmd_t cmd,
    output idc_pkg::div_rsp_t rsp
);
    import idc_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DVD_BITS-1:0] quo_reg, quo_next;
    logic [MAG_BITS-1:0] rem_reg, rem_next;
    logic [MAG_BITS-1:0] dsr_reg, dsr_next;

    logic [MAG_BITS:0]   rem_shift;
    logic [MAG_BITS:0]   rem_diff;
    logic                fits;

    // Trial subtract of the divisor from the shifted remainder
    assign rem_shift = {rem_reg, quo_reg[DVD_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign fits      = rem_shift >= {1'b0, dsr_reg};

    // Load on start, else advance one quotient bit
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = cmd.dividend;
            rem_next  = '0;
            dsr_next  = cmd.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_BITS-2:0], fits};
            rem_next = fits ? rem_diff[MAG_BITS-1:0] : rem_shift[MAG_BITS-1:0];
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(DVD_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/image_dimension_capper_unit.sv =====
// ============================================================================
// image_dimension_capper_unit: cap image dimensions to a memory tier
// A request carries width, height and the largest free block size. The
// block clamps the sides to the tier limits keeping the aspect ratio, then
// shrinks both to nine tenths until the pixel count fits; a nonpositive side skips both.
//
// Usage:
//   Request channel (req_valid/req_ready) takes orig_width, orig_height and
//   largest_free. req_ready is high only while the sequencer is idle; one
//   request is worked on at a time.
//   Result channel (res_valid/res_ready) presents capped_width,
//   capped_height and was_changed from an output register, so the next
//   request may be taken while a result still waits.
//   A nonpositive side goes from idle straight to the final state; sides
//   inside the tier limits run no division. Each clamp runs one division
//   on the shared restoring divider; at most two clamps take effect, as
//   the width recheck after the height clamp never finds the width over.
//   A shrink pass runs ST_SHRINK, then ST_SHRINK_CHK; at most 6 passes.
//   Reset clears the sequencer, the divider and res_valid. A stalled
//   receiver holds the result register; a finished request waits in the
//   final state until the register frees up.
// ============================================================================
module image_dimension_capper_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic signed [idc_pkg::DIM_BITS-1:0] orig_width,
    input  logic signed [idc_pkg::DIM_BITS-1:0] orig_height,
    input  logic        [31:0]            largest_free,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic signed [idc_pkg::DIM_BITS-1:0] capped_width,
    output logic signed [idc_pkg::DIM_BITS-1:0] capped_height,
    output logic                          was_changed
);
    import idc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP_W,
        ST_WAIT_H,
        ST_CLAMP_H,
        ST_WAIT_W,
        ST_RECLAMP_W,
        ST_WAIT_H2,
        ST_SHRINK_CHK,
        ST_SHRINK,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [DIM_BITS-1:0] ow_reg, ow_next;
    logic [DIM_BITS-1:0] oh_reg, oh_next;
    logic [DIM_BITS-1:0] w_reg, w_next;
    logic [DIM_BITS-1:0] h_reg, h_next;
    logic [LIM_BITS-1:0] maxw_reg, maxw_next;
    logic [LIM_BITS-1:0] maxh_reg, maxh_next;
    logic [PIX_BITS-1:0] maxp_reg, maxp_next;
    logic                res_valid_reg, res_valid_next;
    logic [DIM_BITS-1:0] cw_reg, cw_next;
    logic [DIM_BITS-1:0] ch_reg, ch_next;
    logic                chg_reg, chg_next;

    div_cmd_t            div_cmd;
    div_rsp_t            div_rsp;

    logic [MAG_BITS-1:0] mul_a;
    logic [LIM_BITS-1:0] mul_b;
    logic [MAG_BITS-1:0] quo;
    logic [MAG_BITS-1:0] quo_floor;
    logic [PRD_BITS-1:0] pix;
    logic                w_over;
    logic                h_over;
    logic                side_bad;

    // Shared divider
    idc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    // Limit compares and helpers
    assign w_over    = w_reg[MAG_BITS-1:0] > MAG_BITS'(maxw_reg);
    assign h_over    = h_reg[MAG_BITS-1:0] > MAG_BITS'(maxh_reg);
    assign side_bad  = orig_width[DIM_BITS-1] || (orig_width == '0) ||
                       orig_height[DIM_BITS-1] || (orig_height == '0);
    assign quo       = div_rsp.quotient[MAG_BITS-1:0];
    assign quo_floor = (quo == '0) ? MAG_BITS'(1) : quo;
    assign pix       = PRD_BITS'(w_reg[LIM_BITS-1:0]) * PRD_BITS'(h_reg[LIM_BITS-1:0]);

    // Select the dividend operands for the clamp being started
    always_comb
    begin
        case (state_reg)
            ST_CLAMP_W:
            begin
                mul_a = oh_reg[MAG_BITS-1:0];
                mul_b = maxw_reg;
                div_cmd.divisor = ow_reg[MAG_BITS-1:0];
                div_cmd.start   = w_over;
            end
            ST_CLAMP_H:
            begin
                mul_a = ow_reg[MAG_BITS-1:0];
                mul_b = maxh_reg;
                div_cmd.divisor = oh_reg[MAG_BITS-1:0];
                div_cmd.start   = h_over;
            end
            ST_RECLAMP_W:
            begin
                mul_a = h_reg[MAG_BITS-1:0];
                mul_b = maxw_reg;
                div_cmd.divisor = w_reg[MAG_BITS-1:0];
                div_cmd.start   = w_over;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
                div_cmd.divisor = '0;
                div_cmd.start   = 1'b0;
            end
        endcase
        div_cmd.dividend = DVD_BITS'(mul_a) * DVD_BITS'(mul_b);
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        ow_next        = ow_reg;
        oh_next        = oh_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        maxw_next      = maxw_reg;
        maxh_next      = maxh_reg;
        maxp_next      = maxp_reg;
        cw_next        = cw_reg;
        ch_next        = ch_reg;
        chg_next       = chg_reg;
        res_valid_next = res_valid_reg && !res_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    ow_next = orig_width;
                    oh_next = orig_height;
                    w_next  = orig_width;
                    h_next  = orig_height;
                    if (largest_free >= FREE_HI)
                    begin
                        maxw_next = MAXW_HI;
                        maxh_next = MAXH_HI;
                        maxp_next = MAXP_HI;
                    end
                    else if (largest_free >= FREE_MID)
                    begin
                        maxw_next = MAXW_MID;
                        maxh_next = MAXH_MID;
                        maxp_next = MAXP_MID;
                    end
                    else
                    begin
                        maxw_next = MAXW_LO;
                        maxh_next = MAXH_LO;
                        maxp_next = MAXP_LO;
                    end
                    state_next = side_bad ? ST_FINISH : ST_CLAMP_W;
                end
            end
            ST_CLAMP_W:
            begin
                state_next = w_over ? ST_WAIT_H : ST_CLAMP_H;
            end
            ST_WAIT_H:
            begin
                if (div_rsp.done)
                begin
                    h_next     = DIM_BITS'(quo_floor);
                    w_next     = DIM_BITS'(maxw_reg);
                    state_next = ST_CLAMP_H;
                end
            end
            ST_CLAMP_H:
            begin
                state_next = h_over ? ST_WAIT_W : ST_SHRINK_CHK;
            end
            ST_WAIT_W:
            begin
                if (div_rsp.done)
                begin
                    w_next     = DIM_BITS'(quo_floor);
                    h_next     = DIM_BITS'(maxh_reg);
                    state_next = ST_RECLAMP_W;
                end
            end
            ST_RECLAMP_W:
            begin
                state_next = w_over ? ST_WAIT_H2 : ST_SHRINK_CHK;
            end
            ST_WAIT_H2:
            begin
                if (div_rsp.done)
                begin
                    h_next     = DIM_BITS'(quo_floor);
                    w_next     = DIM_BITS'(maxw_reg);
                    state_next = ST_SHRINK_CHK;
                end
            end
            ST_SHRINK_CHK:
            begin
                // Sides are within the tier limits here, so LIM_BITS hold them
                if ((pix > PRD_BITS'(maxp_reg)) &&
                    ((w_reg[MAG_BITS-1:0] > MAG_BITS'(1)) ||
                     (h_reg[MAG_BITS-1:0] > MAG_BITS'(1))))
                begin
                    state_next = ST_SHRINK;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHRINK:
            begin
                w_next     = DIM_BITS'(shrink_side(w_reg[LIM_BITS-1:0]));
                h_next     = DIM_BITS'(shrink_side(h_reg[LIM_BITS-1:0]));
                state_next = ST_SHRINK_CHK;
            end
            ST_FINISH:
            begin
                // Load the result register once it is free
                if (!res_valid_reg || res_ready)
                begin
                    cw_next        = w_reg;
                    ch_next        = h_reg;
                    chg_next       = (w_reg != ow_reg) || (h_reg != oh_reg);
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, working values and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            ow_reg        <= '0;
            oh_reg        <= '0;
            w_reg         <= '0;
            h_reg         <= '0;
            maxw_reg      <= '0;
            maxh_reg      <= '0;
            maxp_reg      <= '0;
            cw_reg        <= '0;
            ch_reg        <= '0;
            chg_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            ow_reg        <= ow_next;
            oh_reg        <= oh_next;
            w_reg         <= w_next;
            h_reg         <= h_next;
            maxw_reg      <= maxw_next;
            maxh_reg      <= maxh_next;
            maxp_reg      <= maxp_next;
            cw_reg        <= cw_next;
            ch_reg        <= ch_next;
            chg_reg       <= chg_next;
        end
    end

    assign req_ready     = (state_reg == ST_IDLE);
    assign res_valid     = res_valid_reg;
    assign capped_width  = cw_reg;
    assign capped_height = ch_reg;
    assign was_changed   = chg_reg;

    // Never restart the divider while it is working
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_cmd.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // An idle sequencer leaves no division in flight
    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> (!div_rsp.busy && !div_rsp.done))
        else $error("division in flight while idle");

    // A changed result always has positive sides
    a_changed_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && was_changed) |->
            (!capped_width[DIM_BITS-1] && (capped_width != '0) &&
             !capped_height[DIM_BITS-1] && (capped_height != '0)))
        else $error("changed result with nonpositive side");

endmodule
